[rtl/nearest_light_sorted_list_defines.svh]
// -----------------------------------------------------------------------------
// Nearest light sorted list assertion macros
// Shared property forms used by the port checker of the light list.
// -----------------------------------------------------------------------------
`ifndef NEAREST_LIGHT_SORTED_LIST_DEFINES_SVH
`define NEAREST_LIGHT_SORTED_LIST_DEFINES_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define NLSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled during reset.
`define NLSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/nlsl_pkg.sv]
// -----------------------------------------------------------------------------
// Nearest light sorted list package
// Field widths, operation and result codes, and controller/datapath types.
// -----------------------------------------------------------------------------
package nlsl_pkg;

    localparam int POS_W     = 25;
    localparam int ORG_W     = 21;
    localparam int KIND_W    = 8;
    localparam int DIST_W    = 52;
    localparam int SLOT_W    = 3;
    localparam int COUNT_W   = 4;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        RES_APPENDED   = 3'd0,
        RES_INSERTED   = 3'd1,
        RES_DROPPED    = 3'd2,
        RES_REJECTED   = 3'd3,
        RES_REMOVED    = 3'd4,
        RES_NOT_FOUND  = 3'd5,
        RES_READ_OK    = 3'd6,
        RES_READ_EMPTY = 3'd7
    } res_t;

    typedef enum logic [1:0] {
        SLOT_ZERO = 2'd0,
        SLOT_IDX  = 2'd1,
        SLOT_READ = 2'd2
    } slot_sel_t;

    typedef enum logic [3:0] {
        S_IDLE     = 4'd0,
        S_DECODE   = 4'd1,
        S_ABS      = 4'd2,
        S_SQR      = 4'd3,
        S_ACC      = 4'd4,
        S_WALK_INS = 4'd5,
        S_WALK_RM  = 4'd6,
        S_READ     = 4'd7,
        S_FINISH   = 4'd8
    } fsm_t;

    typedef struct packed {
        logic      capture;
        logic      abs_en;
        logic      sq_en;
        logic      acc_en;
        logic      idx_inc;
        logic      insert;
        logic      remove;
        logic      out_load;
        res_t      out_status;
        slot_sel_t out_slot_sel;
        logic      out_data_en;
    } dp_cmd_t;

    typedef struct packed {
        logic            axis_last;
        logic            idx_full;
        logic            idx_ge_count;
        logic            dist_less;
        logic            pos_match;
        logic            list_full;
        logic            read_hit;
        logic            out_busy;
        logic [OP_W-1:0] op;
    } dp_status_t;

endpackage

[rtl/nlsl_ctrl.sv]
// -----------------------------------------------------------------------------
// Nearest light sorted list controller
// Sequences distance computation, the slot walk and result delivery.
// -----------------------------------------------------------------------------
module nlsl_ctrl
    import nlsl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    fsm_t      state_reg, state_next;
    res_t      res_code_reg, res_code_next;
    slot_sel_t res_slot_reg, res_slot_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            res_code_reg <= RES_READ_EMPTY;
            res_slot_reg <= SLOT_ZERO;
        end else begin
            state_reg    <= state_next;
            res_code_reg <= res_code_next;
            res_slot_reg <= res_slot_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        res_code_next = res_code_reg;
        res_slot_next = res_slot_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (op_t'(status.op))
                    OP_INSERT: state_next = S_ABS;
                    OP_REMOVE: state_next = S_WALK_RM;
                    OP_READ:   state_next = S_READ;
                    default: begin
                        res_code_next = RES_READ_EMPTY;
                        res_slot_next = SLOT_ZERO;
                        state_next    = S_FINISH;
                    end
                endcase
            end
            S_ABS: begin
                state_next = S_SQR;
            end
            S_SQR: begin
                if (status.axis_last) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                state_next = S_WALK_INS;
            end
            S_WALK_INS: begin
                if (status.idx_full) begin
                    res_code_next = RES_REJECTED;
                    res_slot_next = SLOT_ZERO;
                    state_next    = S_FINISH;
                end else if (status.idx_ge_count) begin
                    res_code_next = RES_APPENDED;
                    res_slot_next = SLOT_IDX;
                    state_next    = S_FINISH;
                end else if (status.dist_less) begin
                    res_code_next = status.list_full ? RES_DROPPED : RES_INSERTED;
                    res_slot_next = SLOT_IDX;
                    state_next    = S_FINISH;
                end
            end
            S_WALK_RM: begin
                if (status.idx_ge_count) begin
                    res_code_next = RES_NOT_FOUND;
                    res_slot_next = SLOT_ZERO;
                    state_next    = S_FINISH;
                end else if (status.pos_match) begin
                    res_code_next = RES_REMOVED;
                    res_slot_next = SLOT_IDX;
                    state_next    = S_FINISH;
                end
            end
            S_READ: begin
                res_code_next = status.read_hit ? RES_READ_OK : RES_READ_EMPTY;
                res_slot_next = SLOT_READ;
                state_next    = S_FINISH;
            end
            S_FINISH: begin
                if (!status.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd              = '0;
        cmd.out_status   = res_code_reg;
        cmd.out_slot_sel = res_slot_reg;
        cmd.out_data_en  = (res_code_reg == RES_READ_OK);
        s_ready          = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_ABS: begin
                cmd.abs_en = 1'b1;
            end
            S_SQR: begin
                cmd.sq_en = 1'b1;
            end
            S_ACC: begin
                cmd.acc_en = 1'b1;
            end
            S_WALK_INS: begin
                cmd.insert  = !status.idx_full && (status.idx_ge_count || status.dist_less);
                cmd.idx_inc = !status.idx_full && !status.idx_ge_count && !status.dist_less;
            end
            S_WALK_RM: begin
                cmd.remove  = !status.idx_ge_count && status.pos_match;
                cmd.idx_inc = !status.idx_ge_count && !status.pos_match;
            end
            S_FINISH: begin
                cmd.out_load = !status.out_busy;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/nlsl_datapath.sv]
// -----------------------------------------------------------------------------
// Nearest light sorted list datapath
// Origin registers, distance unit, slot storage with shifting, result register.
// -----------------------------------------------------------------------------
module nlsl_datapath
    import nlsl_pkg::*;
#(
    parameter int LIGHT_SLOTS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [ORG_W-1:0]         cfg_wdata,
    input  logic [OP_W-1:0]          s_op,
    input  logic signed [POS_W-1:0]  s_pos_x,
    input  logic signed [POS_W-1:0]  s_pos_y,
    input  logic signed [POS_W-1:0]  s_pos_z,
    input  logic [KIND_W-1:0]        s_light_kind,
    input  logic [SLOT_W-1:0]        s_read_slot,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_status,
    output logic [SLOT_W-1:0]        m_slot,
    output logic [COUNT_W-1:0]       m_entry_count,
    output logic signed [POS_W-1:0]  m_out_x,
    output logic signed [POS_W-1:0]  m_out_y,
    output logic signed [POS_W-1:0]  m_out_z,
    output logic [KIND_W-1:0]        m_out_kind,
    output logic [DIST_W-1:0]        m_out_distance
);

    localparam int CNT_W = $clog2(LIGHT_SLOTS + 1);
    localparam int IDX_W = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int ABS_W = POS_W + 1;
    localparam int ORIGIN_SHIFT = 4;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    function automatic logic [ABS_W-1:0] axis_abs(
        input logic [POS_W-1:0] pos,
        input logic [ORG_W-1:0] org
    );
        logic [ABS_W-1:0] diff;
        diff = {pos[POS_W-1], pos} - {org[ORG_W-1], org, {ORIGIN_SHIFT{1'b0}}};
        return diff[ABS_W-1] ? (~diff + 1'b1) : diff;
    endfunction

    logic signed [ORG_W-1:0] org_x_reg, org_y_reg, org_z_reg;

    logic [OP_W-1:0]   op_reg;
    logic [POS_W-1:0]  pos_x_reg, pos_y_reg, pos_z_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [SLOT_W-1:0] rslot_reg;

    logic [ABS_W-1:0]  abs_x_reg, abs_y_reg, abs_z_reg;
    logic [ABS_W-1:0]  abs_sel;
    axis_t             axis_reg;
    logic [DIST_W-1:0] sq_reg, acc_reg, sq_calc;

    logic [CNT_W-1:0]  idx_reg, count_reg;
    logic [IDX_W-1:0]  idx;

    logic [POS_W-1:0]  slot_x [LIGHT_SLOTS];
    logic [POS_W-1:0]  slot_y [LIGHT_SLOTS];
    logic [POS_W-1:0]  slot_z [LIGHT_SLOTS];
    logic [DIST_W-1:0] slot_distance [LIGHT_SLOTS];
    logic [KIND_W-1:0] slot_kind [LIGHT_SLOTS];

    logic [POS_W-1:0]  rd_x, rd_y, rd_z;
    logic [DIST_W-1:0] rd_distance;
    logic [KIND_W-1:0] rd_kind;

    logic              m_valid_reg;
    logic [2:0]        m_status_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    logic [COUNT_W-1:0] m_entry_count_reg;
    logic [POS_W-1:0]  m_out_x_reg, m_out_y_reg, m_out_z_reg;
    logic [KIND_W-1:0] m_out_kind_reg;
    logic [DIST_W-1:0] m_out_distance_reg;

    assign idx         = idx_reg[IDX_W-1:0];
    assign rd_x        = slot_x[idx];
    assign rd_y        = slot_y[idx];
    assign rd_z        = slot_z[idx];
    assign rd_distance = slot_distance[idx];
    assign rd_kind     = slot_kind[idx];

    always_comb begin
        case (axis_reg)
            AXIS_X:  abs_sel = abs_x_reg;
            AXIS_Y:  abs_sel = abs_y_reg;
            default: abs_sel = abs_z_reg;
        endcase
    end

    assign sq_calc = abs_sel * abs_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ORIGIN_X: org_x_reg <= cfg_wdata;
                CFG_ORIGIN_Y: org_y_reg <= cfg_wdata;
                CFG_ORIGIN_Z: org_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_op;
            pos_x_reg <= s_pos_x;
            pos_y_reg <= s_pos_y;
            pos_z_reg <= s_pos_z;
            kind_reg  <= s_light_kind;
            rslot_reg <= s_read_slot;
        end
        if (cmd.abs_en) begin
            abs_x_reg <= axis_abs(pos_x_reg, org_x_reg);
            abs_y_reg <= axis_abs(pos_y_reg, org_y_reg);
            abs_z_reg <= axis_abs(pos_z_reg, org_z_reg);
        end
        if (cmd.capture) begin
            sq_reg   <= '0;
            acc_reg  <= '0;
            axis_reg <= AXIS_X;
        end else if (cmd.sq_en) begin
            sq_reg   <= sq_calc;
            acc_reg  <= acc_reg + sq_reg;
            axis_reg <= axis_t'(axis_reg + 2'd1);
        end else if (cmd.acc_en) begin
            acc_reg  <= acc_reg + sq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.capture) begin
                idx_reg <= (op_t'(s_op) == OP_READ) ? CNT_W'(s_read_slot) : '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.insert && (count_reg != CNT_W'(LIGHT_SLOTS))) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.remove) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            for (int n = 1; n < LIGHT_SLOTS; n++) begin
                if (CNT_W'(n) > idx_reg) begin
                    slot_x[n]        <= slot_x[n-1];
                    slot_y[n]        <= slot_y[n-1];
                    slot_z[n]        <= slot_z[n-1];
                    slot_distance[n] <= slot_distance[n-1];
                    slot_kind[n]     <= slot_kind[n-1];
                end
            end
            slot_x[idx]        <= pos_x_reg;
            slot_y[idx]        <= pos_y_reg;
            slot_z[idx]        <= pos_z_reg;
            slot_distance[idx] <= acc_reg;
            slot_kind[idx]     <= kind_reg;
        end else if (cmd.remove) begin
            for (int n = 0; n < LIGHT_SLOTS - 1; n++) begin
                if (CNT_W'(n) >= idx_reg) begin
                    slot_x[n]        <= slot_x[n+1];
                    slot_y[n]        <= slot_y[n+1];
                    slot_z[n]        <= slot_z[n+1];
                    slot_distance[n] <= slot_distance[n+1];
                    slot_kind[n]     <= slot_kind[n+1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg      <= cmd.out_status;
            m_entry_count_reg <= COUNT_W'(count_reg);
            case (cmd.out_slot_sel)
                SLOT_IDX:  m_slot_reg <= SLOT_W'(idx_reg);
                SLOT_READ: m_slot_reg <= rslot_reg;
                default:   m_slot_reg <= '0;
            endcase
            if (cmd.out_data_en) begin
                m_out_x_reg        <= rd_x;
                m_out_y_reg        <= rd_y;
                m_out_z_reg        <= rd_z;
                m_out_kind_reg     <= rd_kind;
                m_out_distance_reg <= rd_distance;
            end else begin
                m_out_x_reg        <= '0;
                m_out_y_reg        <= '0;
                m_out_z_reg        <= '0;
                m_out_kind_reg     <= '0;
                m_out_distance_reg <= '0;
            end
        end
    end

    assign status.axis_last    = (axis_reg == AXIS_Z);
    assign status.idx_full     = (idx_reg == CNT_W'(LIGHT_SLOTS));
    assign status.idx_ge_count = (idx_reg >= count_reg);
    assign status.dist_less    = (acc_reg < rd_distance);
    assign status.pos_match    = (rd_x == pos_x_reg) && (rd_y == pos_y_reg)
                                 && (rd_z == pos_z_reg);
    assign status.list_full    = (count_reg == CNT_W'(LIGHT_SLOTS));
    assign status.read_hit     = (CMP_W'(rslot_reg) < CMP_W'(count_reg));
    assign status.out_busy     = m_valid_reg && !m_ready;
    assign status.op           = op_reg;

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot         = m_slot_reg;
    assign m_entry_count  = m_entry_count_reg;
    assign m_out_x        = m_out_x_reg;
    assign m_out_y        = m_out_y_reg;
    assign m_out_z        = m_out_z_reg;
    assign m_out_kind     = m_out_kind_reg;
    assign m_out_distance = m_out_distance_reg;

endmodule

[rtl/nearest_light_sorted_list.sv]
// -----------------------------------------------------------------------------
// Nearest light sorted list: an insert runs decode, absolute differences, the shared squarer
// over the three axes, accumulation and a list walk of one slot per cycle; a remove walks the
// list and a read looks up its slot. A new beat is accepted only after the result is loaded.
// Synchronous active-low reset empties the list and zeroes the origin; slot data is not cleared.
// -----------------------------------------------------------------------------
module nearest_light_sorted_list
    import nlsl_pkg::*;
#(
    parameter int LIGHT_SLOTS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [ORG_W-1:0]         cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_op,
    input  logic signed [POS_W-1:0]  s_pos_x,
    input  logic signed [POS_W-1:0]  s_pos_y,
    input  logic signed [POS_W-1:0]  s_pos_z,
    input  logic [KIND_W-1:0]        s_light_kind,
    input  logic [SLOT_W-1:0]        s_read_slot,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_status,
    output logic [SLOT_W-1:0]        m_slot,
    output logic [COUNT_W-1:0]       m_entry_count,
    output logic signed [POS_W-1:0]  m_out_x,
    output logic signed [POS_W-1:0]  m_out_y,
    output logic signed [POS_W-1:0]  m_out_z,
    output logic [KIND_W-1:0]        m_out_kind,
    output logic [DIST_W-1:0]        m_out_distance
);

    dp_cmd_t    cmd;
    dp_status_t status;

    nlsl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    nlsl_datapath #(
        .LIGHT_SLOTS (LIGHT_SLOTS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_op           (s_op),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .s_light_kind   (s_light_kind),
        .s_read_slot    (s_read_slot),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_slot         (m_slot),
        .m_entry_count  (m_entry_count),
        .m_out_x        (m_out_x),
        .m_out_y        (m_out_y),
        .m_out_z        (m_out_z),
        .m_out_kind     (m_out_kind),
        .m_out_distance (m_out_distance)
    );

endmodule

[rtl/nlsl_checker.sv]
// -----------------------------------------------------------------------------
// Nearest light sorted list port checker
// Watches the result channel for handshake and result consistency.
// -----------------------------------------------------------------------------
`include "nearest_light_sorted_list_defines.svh"

module nlsl_checker
    import nlsl_pkg::*;
#(
    parameter int LIGHT_SLOTS = 8
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [2:0]               m_status,
    input logic [SLOT_W-1:0]        m_slot,
    input logic [COUNT_W-1:0]       m_entry_count,
    input logic signed [POS_W-1:0]  m_out_x,
    input logic signed [POS_W-1:0]  m_out_y,
    input logic signed [POS_W-1:0]  m_out_z,
    input logic [KIND_W-1:0]        m_out_kind,
    input logic [DIST_W-1:0]        m_out_distance
);

    // A stalled result beat must hold.
    `NLSL_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_slot) && $stable(m_entry_count) && $stable(m_out_distance), "result beat changed while stalled")

    // Only a successful read carries entry data.
    `NLSL_ASSERT_NOW(a_data_zero, m_valid && (m_status != RES_READ_OK), (m_out_x == '0) && (m_out_y == '0) && (m_out_z == '0) && (m_out_kind == '0) && (m_out_distance == '0), "data present on a beat that is not a read hit")

    // A rejected light means the list was full and reports no slot.
    `NLSL_ASSERT_NOW(a_reject_full, m_valid && (m_status == RES_REJECTED), (m_slot == '0) && (m_entry_count == COUNT_W'(LIGHT_SLOTS)), "reject reported on a list that is not full")

    // Dropping the last entry only happens on a full list.
    `NLSL_ASSERT_NOW(a_drop_full, m_valid && (m_status == RES_DROPPED), m_entry_count == COUNT_W'(LIGHT_SLOTS), "drop reported on a list that is not full")

endmodule

bind nearest_light_sorted_list nlsl_checker #(
    .LIGHT_SLOTS (LIGHT_SLOTS)
) u_nlsl_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_slot         (m_slot),
    .m_entry_count  (m_entry_count),
    .m_out_x        (m_out_x),
    .m_out_y        (m_out_y),
    .m_out_z        (m_out_z),
    .m_out_kind     (m_out_kind),
    .m_out_distance (m_out_distance)
);

[test/nearest_light_sorted_list_tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Nearest light sorted list testbench
// Drives insert, remove, read and unused-opcode requests with random gaps on both channels and
// compares every result beat against a local model of the distance-sorted list.
// The origin registers are changed between phases while the block is idle.
// -----------------------------------------------------------------------------
module nearest_light_sorted_list_tb;
    import nlsl_pkg::*;

    localparam int LIGHT_SLOTS      = 8;
    localparam int ORIGIN_SCALE     = 16;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int PHASES           = 6;
    localparam int HOLD_CYCLES      = 300;
    localparam int RUN_LIMIT_CYCLES = 300000;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [POS_W-1:0] POS_MAX = 25'sh0FFFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 25'sh1000000;
    localparam logic signed [ORG_W-1:0] ORG_MAX = 21'sh0FFFFF;
    localparam logic signed [ORG_W-1:0] ORG_MIN = 21'sh100000;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [KIND_W-1:0]       kind;
        logic [SLOT_W-1:0]       read_slot;
    } light_request_t;

    typedef struct {
        res_t                    status;
        logic [SLOT_W-1:0]       slot;
        logic [COUNT_W-1:0]      count;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [KIND_W-1:0]       kind;
        logic [DIST_W-1:0]       distance;
    } light_reply_t;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [ORG_W-1:0]        cfg_wdata     = '0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic [OP_W-1:0]         s_op          = '0;
    logic signed [POS_W-1:0] s_pos_x       = '0;
    logic signed [POS_W-1:0] s_pos_y       = '0;
    logic signed [POS_W-1:0] s_pos_z       = '0;
    logic [KIND_W-1:0]       s_light_kind  = '0;
    logic [SLOT_W-1:0]       s_read_slot   = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic [2:0]              m_status;
    logic [SLOT_W-1:0]       m_slot;
    logic [COUNT_W-1:0]      m_entry_count;
    logic signed [POS_W-1:0] m_out_x;
    logic signed [POS_W-1:0] m_out_y;
    logic signed [POS_W-1:0] m_out_z;
    logic [KIND_W-1:0]       m_out_kind;
    logic [DIST_W-1:0]       m_out_distance;

    nearest_light_sorted_list #(
        .LIGHT_SLOTS(LIGHT_SLOTS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pos_z       (s_pos_z),
        .s_light_kind  (s_light_kind),
        .s_read_slot   (s_read_slot),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot        (m_slot),
        .m_entry_count (m_entry_count),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_out_z       (m_out_z),
        .m_out_kind    (m_out_kind),
        .m_out_distance(m_out_distance)
    );

    // Model of the list and of the origin registers.
    logic signed [ORG_W-1:0] origin_x = '0;
    logic signed [ORG_W-1:0] origin_y = '0;
    logic signed [ORG_W-1:0] origin_z = '0;
    logic signed [POS_W-1:0] list_x [LIGHT_SLOTS];
    logic signed [POS_W-1:0] list_y [LIGHT_SLOTS];
    logic signed [POS_W-1:0] list_z [LIGHT_SLOTS];
    logic [DIST_W-1:0]       list_dist [LIGHT_SLOTS];
    logic [KIND_W-1:0]       list_kind [LIGHT_SLOTS];
    int                      list_entries = 0;

    light_request_t queued_requests[$];
    light_reply_t   expected_replies[$];
    light_request_t beat_request;
    logic           send_busy      = 1'b0;
    int             send_gap       = 0;
    int             ready_wait     = 0;
    int             hold_left      = 0;
    int             stall_requests = 0;
    int             stalls_served  = 0;
    logic           idle_free      = 1'b0;
    int             mismatch_count = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [DIST_W-1:0] axis_square(logic signed [POS_W-1:0] p,
                                                      logic signed [ORG_W-1:0] o);
        longint delta;
        delta = longint'(p) - longint'(o) * ORIGIN_SCALE;
        if (delta < 0) begin
            delta = -delta;
        end
        return DIST_W'(delta * delta);
    endfunction

    function automatic void move_entry(int dst, int src);
        list_x[dst]    = list_x[src];
        list_y[dst]    = list_y[src];
        list_z[dst]    = list_z[src];
        list_dist[dst] = list_dist[src];
        list_kind[dst] = list_kind[src];
    endfunction

    function automatic light_reply_t predict_list_op(light_request_t req);
        light_reply_t      r;
        logic [DIST_W-1:0] light_dist;
        int                at;
        r.status   = RES_READ_EMPTY;
        r.slot     = '0;
        r.x        = '0;
        r.y        = '0;
        r.z        = '0;
        r.kind     = '0;
        r.distance = '0;
        at         = -1;
        case (req.op)
            OP_INSERT: begin
                light_dist = axis_square(req.x, origin_x) + axis_square(req.y, origin_y)
                           + axis_square(req.z, origin_z);
                r.status = RES_REJECTED;
                for (int i = 0; i < LIGHT_SLOTS && at < 0; i++) begin
                    if (i >= list_entries) begin
                        r.status = RES_APPENDED;
                        at = i;
                    end else if (light_dist < list_dist[i]) begin
                        if (list_entries < LIGHT_SLOTS) begin
                            r.status = RES_INSERTED;
                        end else begin
                            r.status = RES_DROPPED;
                        end
                        at = i;
                        for (int n = LIGHT_SLOTS - 1; n > i; n--) begin
                            move_entry(n, n - 1);
                        end
                    end
                end
                if (at >= 0) begin
                    list_x[at]    = req.x;
                    list_y[at]    = req.y;
                    list_z[at]    = req.z;
                    list_dist[at] = light_dist;
                    list_kind[at] = req.kind;
                    if (list_entries < LIGHT_SLOTS) begin
                        list_entries++;
                    end
                    r.slot = SLOT_W'(at);
                end
            end
            OP_REMOVE: begin
                r.status = RES_NOT_FOUND;
                for (int i = 0; i < list_entries && at < 0; i++) begin
                    if (list_x[i] == req.x && list_y[i] == req.y && list_z[i] == req.z) begin
                        at = i;
                    end
                end
                if (at >= 0) begin
                    for (int n = at; n + 1 < LIGHT_SLOTS; n++) begin
                        move_entry(n, n + 1);
                    end
                    list_entries--;
                    r.status = RES_REMOVED;
                    r.slot   = SLOT_W'(at);
                end
            end
            OP_READ: begin
                r.slot = req.read_slot;
                if (req.read_slot < list_entries) begin
                    r.status   = RES_READ_OK;
                    r.x        = list_x[req.read_slot];
                    r.y        = list_y[req.read_slot];
                    r.z        = list_z[req.read_slot];
                    r.kind     = list_kind[req.read_slot];
                    r.distance = list_dist[req.read_slot];
                end
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(list_entries);
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] pick_coord(logic signed [ORG_W-1:0] org);
        longint center;
        center = longint'(org) * ORIGIN_SCALE;
        case ($urandom_range(0, 3))
            0: return POS_W'(center + longint'($urandom_range(0, 8)) - 4);
            1: return POS_W'(center + longint'($urandom_range(0, 2047)) - 1024);
            2: return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
            default: return POS_W'($urandom);
        endcase
    endfunction

    task automatic queue_request(logic [OP_W-1:0] op, logic signed [POS_W-1:0] x,
                                 logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z,
                                 logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] read_slot);
        light_request_t req;
        req.op        = op;
        req.x         = x;
        req.y         = y;
        req.z         = z;
        req.kind      = kind;
        req.read_slot = read_slot;
        queued_requests.push_back(req);
    endtask

    task automatic write_origin(logic [CFG_IDX_W-1:0] idx, logic signed [ORG_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ORIGIN_X: origin_x = value;
            CFG_ORIGIN_Y: origin_y = value;
            CFG_ORIGIN_Z: origin_z = value;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        if (mismatch_count < 100) begin
            $display("%0t: %s got %0h, expected %0h", $realtime, field, got, want);
        end
        mismatch_count++;
    endtask

    // Request driver: one beat held until accepted, then a random gap (none in the last phase).
    always @(posedge aclk) begin
        if (!aresetn) begin
            send_busy = 1'b0;
            send_gap  = 0;
            s_valid   <= 1'b0;
        end else begin
            if (send_busy && s_ready) begin
                expected_replies.push_back(predict_list_op(beat_request));
                send_busy = 1'b0;
                send_gap  = idle_free ? 0 : $urandom_range(0, 9);
            end
            if (!send_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (queued_requests.size() != 0) begin
                    beat_request = queued_requests.pop_front();
                    s_op         <= beat_request.op;
                    s_pos_x      <= beat_request.x;
                    s_pos_y      <= beat_request.y;
                    s_pos_z      <= beat_request.z;
                    s_light_kind <= beat_request.kind;
                    s_read_slot  <= beat_request.read_slot;
                    send_busy    = 1'b1;
                end
            end
            s_valid <= send_busy;
        end
    end

    // Result receiver: random wait after each beat (none in the last phase), plus long hold-offs on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            ready_wait = 0;
            hold_left  = 0;
            m_ready    <= 1'b0;
        end else begin
            if (stall_requests != stalls_served) begin
                hold_left = HOLD_CYCLES;
                stalls_served++;
            end
            if (m_valid && m_ready) begin
                ready_wait = idle_free ? 0 : $urandom_range(0, 9);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (ready_wait > 0) begin
                ready_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        light_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected result beat, status", m_status, 0);
            end else begin
                want = expected_replies.pop_front();
                if (m_status !== want.status) begin
                    report_mismatch("status", m_status, want.status);
                end
                if (m_slot !== want.slot) begin
                    report_mismatch("slot", m_slot, want.slot);
                end
                if (m_entry_count !== want.count) begin
                    report_mismatch("entry_count", m_entry_count, want.count);
                end
                if (m_out_x !== want.x) begin
                    report_mismatch("out_x", m_out_x, want.x);
                end
                if (m_out_y !== want.y) begin
                    report_mismatch("out_y", m_out_y, want.y);
                end
                if (m_out_z !== want.z) begin
                    report_mismatch("out_z", m_out_z, want.z);
                end
                if (m_out_kind !== want.kind) begin
                    report_mismatch("out_kind", m_out_kind, want.kind);
                end
                if (m_out_distance !== want.distance) begin
                    report_mismatch("out_distance", m_out_distance, want.distance);
                end
            end
        end
    end

    initial begin
        light_request_t req;
        light_request_t recent_lights[$];
        int             pick;
        int             idx;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        queue_request(OP_READ,   0, 0, 0, 8'h00, 3'd0);
        queue_request(OP_REMOVE, 0, 0, 0, 8'h00, 3'd0);
        queue_request(OP_UNUSED, 0, 0, 0, 8'h00, 3'd5);
        queue_request(OP_INSERT, POS_MAX, POS_MAX, POS_MAX, 8'hFF, 3'd0);
        queue_request(OP_INSERT, POS_MIN, POS_MIN, POS_MIN, 8'h00, 3'd0);
        queue_request(OP_INSERT, 0, 0, 0, 8'h5A, 3'd0);
        queue_request(OP_INSERT, 0, 0, 0, 8'hA5, 3'd0);
        queue_request(OP_INSERT, 1, 0, 0, 8'h01, 3'd0);
        queue_request(OP_INSERT, 0, -2, 0, 8'h02, 3'd0);
        queue_request(OP_INSERT, 0, 0, 3, 8'h03, 3'd0);
        queue_request(OP_INSERT, 5, -5, 5, 8'h04, 3'd0);
        queue_request(OP_INSERT, POS_MIN, POS_MIN, POS_MIN, 8'h10, 3'd0);
        queue_request(OP_INSERT, 0, 1, 0, 8'h20, 3'd0);
        queue_request(OP_READ,   0, 0, 0, 8'h00, 3'd0);
        queue_request(OP_READ,   0, 0, 0, 8'h00, 3'd7);
        queue_request(OP_READ,   0, 0, 0, 8'h00, 3'd3);
        queue_request(OP_REMOVE, 0, 0, 3, 8'h00, 3'd0);
        queue_request(OP_REMOVE, 7, 7, 7, 8'h00, 3'd0);
        queue_request(OP_READ,   0, 0, 0, 8'h00, 3'd7);
        queue_request(OP_REMOVE, POS_MAX, POS_MAX, POS_MAX, 8'h00, 3'd0);
        queue_request(OP_REMOVE, 0, 0, 0, 8'h00, 3'd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: ;
                1: begin
                    write_origin(CFG_ORIGIN_X, ORG_MAX);
                    write_origin(CFG_ORIGIN_Y, ORG_MAX);
                    write_origin(CFG_ORIGIN_Z, ORG_MAX);
                end
                2: begin
                    write_origin(CFG_ORIGIN_X, ORG_MIN);
                    write_origin(CFG_ORIGIN_Y, ORG_MIN);
                    write_origin(CFG_ORIGIN_Z, ORG_MIN);
                end
                3: begin
                    write_origin(CFG_ORIGIN_X, ORG_MAX);
                    write_origin(CFG_ORIGIN_Y, ORG_MIN);
                    write_origin(CFG_ORIGIN_Z, '0);
                end
                default: begin
                    write_origin(CFG_ORIGIN_X, ORG_W'($urandom));
                    write_origin(CFG_ORIGIN_Y, ORG_W'($urandom));
                    write_origin(CFG_ORIGIN_Z, ORG_W'($urandom));
                end
            endcase
            idle_free = (phase == PHASES - 1);
            if (phase == 4) begin
                stall_requests++;
            end
            recent_lights.delete();
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                pick          = $urandom_range(0, 99);
                req.x         = pick_coord(origin_x);
                req.y         = pick_coord(origin_y);
                req.z         = pick_coord(origin_z);
                req.kind      = $urandom_range(0, 255);
                req.read_slot = $urandom_range(0, 7);
                if (pick < 40) begin
                    req.op = OP_INSERT;
                    recent_lights.push_back(req);
                    if (recent_lights.size() > 12) begin
                        recent_lights.delete(0);
                    end
                end else if (pick < 70) begin
                    req.op = OP_REMOVE;
                    if (recent_lights.size() != 0 && $urandom_range(0, 3) != 0) begin
                        idx   = $urandom_range(0, recent_lights.size() - 1);
                        req.x = recent_lights[idx].x;
                        req.y = recent_lights[idx].y;
                        req.z = recent_lights[idx].z;
                        recent_lights.delete(idx);
                    end
                end else if (pick < 95) begin
                    req.op = OP_READ;
                end else begin
                    req.op = OP_UNUSED;
                end
                queued_requests.push_back(req);
            end
            while (queued_requests.size() != 0 || send_busy || expected_replies.size() != 0) begin
                @(posedge aclk);
            end
        end

        repeat (30) @(posedge aclk);
        if (mismatch_count == 0 && expected_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        repeat (RUN_LIMIT_CYCLES) @(posedge aclk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/nlsl_pkg.sv
rtl/nlsl_ctrl.sv
rtl/nlsl_datapath.sv
rtl/nearest_light_sorted_list.sv
rtl/nlsl_checker.sv
test/nearest_light_sorted_list_tb.sv
